FILE: rtl/rmh_pkg.sv
// Shared types and codes of the reservation min-heap.
package rmh_pkg;

  localparam int unsigned PatronW = 16;
  localparam int unsigned PrioW   = 8;
  localparam int unsigned OccW    = 6;

  typedef enum logic {
    OP_INSERT  = 1'b0,
    OP_EXTRACT = 1'b1
  } opcode_e;

  typedef enum logic [1:0] {
    ST_INSERTED  = 2'd0,
    ST_EXTRACTED = 2'd1,
    ST_EMPTY     = 2'd2,
    ST_FULL      = 2'd3
  } status_e;

  typedef struct packed {
    opcode_e            opcode;
    logic [PatronW-1:0] patron_id;
    logic [PrioW-1:0]   priority_req;
  } req_t;

  typedef struct packed {
    status_e            status;
    logic [PatronW-1:0] out_patron;
    logic [PrioW-1:0]   out_priority;
    logic [OccW-1:0]    occupancy;
    logic               is_empty;
  } rsp_t;

endpackage

FILE: rtl/rmh_stream_if.sv
// Valid/ready channel interface that carries one request or result payload.
interface rmh_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

FILE: rtl/rmh_ram.sv
// Generic single-write, single-read RAM with registered read data.
module rmh_ram #(
  parameter int unsigned WIDTH = 56,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

FILE: rtl/reservation_min_heap_top.sv
// Top level of the reservation min-heap priority queue.
//
// A binary min-heap of up to CAPACITY reservations, kept in one RAM with a
// single write port and a single registered read port. An insert request
// stores a patron and priority together with an arrival stamp and sifts the
// entry up; an extract request returns the root and sifts the last entry
// down from the root. Lower priority values come first, and among equal
// priorities the earlier arrival wins; the stamp counter returns to zero
// whenever the heap becomes empty. Every request produces exactly one result
// that reports status and occupancy. The block handles one request at a time
// and holds ready low while it works. An insert reads the parent of the hole
// and, while the new entry goes before it, moves that parent down into the
// hole, which rises a level; the entry is written where the hole stops. An
// extract reads the root and then the last entry, and at each level reads the
// left and right children and moves the child that goes first into the hole
// while it goes before the moved entry. Full-heap inserts and empty-heap
// extracts are answered without writing the RAM. With the default depth of
// 32 entries the heap has six levels. The sequencer is paced by the one
// registered RAM read port and by the single compare unit that it uses once
// per step. A finished result sits in an output register, so the next
// request is taken while the previous result still waits for the consumer;
// a second finished result waits in the sequencer until that register frees.
module reservation_min_heap_top #(
  parameter int unsigned CAPACITY   = 32,
  parameter int unsigned STAMP_BITS = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  rmh_stream_if.sink          req_i,
  rmh_stream_if.source        rsp_o
);
  import rmh_pkg::*;

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned IW = AW + 2;
  localparam int unsigned EW = PatronW + PrioW + STAMP_BITS;

  typedef struct packed {
    logic [PatronW-1:0]    patron;
    logic [PrioW-1:0]      prio;
    logic [STAMP_BITS-1:0] stamp;
  } entry_t;

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_UP_RD   = 4'd1;
  localparam logic [3:0] S_UP_CMP  = 4'd2;
  localparam logic [3:0] S_EX_ROOT = 4'd3;
  localparam logic [3:0] S_EX_LAST = 4'd4;
  localparam logic [3:0] S_DN_RD_L = 4'd5;
  localparam logic [3:0] S_DN_RD_R = 4'd6;
  localparam logic [3:0] S_DN_CMP  = 4'd7;
  localparam logic [3:0] S_RESP    = 4'd8;

  // Entry a is served before entry b.
  function automatic logic goes_before(entry_t a, entry_t b);
    logic res;
    if (a.prio != b.prio) begin
      res = a.prio < b.prio;
    end else begin
      res = a.stamp < b.stamp;
    end
    return res;
  endfunction

  logic [3:0]            state_q, state_d;
  logic [CW-1:0]         count_q, count_d;
  logic [STAMP_BITS-1:0] stamp_q, stamp_d;
  logic [AW-1:0]         pos_q, pos_d;
  entry_t                item_q, item_d;
  entry_t                best_q, best_d;
  logic                  best_l_q, best_l_d;
  logic                  has_r_q, has_r_d;
  rsp_t                  resp_q, resp_d;
  logic                  out_valid_q, out_valid_d;
  rsp_t                  out_q, out_d;

  logic                  ram_we;
  logic [AW-1:0]         ram_waddr;
  entry_t                ram_wdata;
  logic [AW-1:0]         ram_raddr;
  logic [EW-1:0]         ram_rdata_raw;
  entry_t                ram_rdata;

  entry_t                cmp_a, cmp_b;
  logic                  cmp_before;

  logic                  accept;
  logic [AW-1:0]         pos_m1;
  logic [AW-1:0]         parent;
  logic [IW-1:0]         lchild;
  logic [IW-1:0]         rchild;
  logic [IW-1:0]         count_w;
  logic                  is_full;

  rmh_ram #(
    .WIDTH(EW),
    .DEPTH(CAPACITY)
  ) u_heap_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata_raw)
  );

  assign ram_rdata = entry_t'(ram_rdata_raw);

  assign req_i.ready   = (state_q == S_IDLE);
  assign accept        = req_i.valid && req_i.ready;
  assign rsp_o.valid   = out_valid_q;
  assign rsp_o.payload = out_q;

  assign pos_m1  = pos_q - AW'(1);
  assign parent  = pos_m1 >> 1;
  assign lchild  = {1'b0, pos_q, 1'b1};
  assign rchild  = lchild + IW'(1);
  assign count_w = IW'(count_q);
  assign is_full = (count_q == CW'(CAPACITY));

  // The one compare unit; its operands follow the sequencer step.
  always_comb begin
    unique case (state_q)
      S_DN_RD_R: begin
        cmp_a = ram_rdata;
        cmp_b = item_q;
      end
      S_DN_CMP: begin
        cmp_a = ram_rdata;
        cmp_b = best_q;
      end
      default: begin
        cmp_a = item_q;
        cmp_b = ram_rdata;
      end
    endcase
  end

  assign cmp_before = goes_before(cmp_a, cmp_b);

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    stamp_d     = stamp_q;
    pos_d       = pos_q;
    item_d      = item_q;
    best_d      = best_q;
    best_l_d    = best_l_q;
    has_r_d     = has_r_q;
    resp_d      = resp_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !rsp_o.ready;
    ram_we      = 1'b0;
    ram_waddr   = pos_q;
    ram_wdata   = item_q;
    ram_raddr   = parent;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          resp_d.out_patron   = '0;
          resp_d.out_priority = '0;
          if (req_i.payload.opcode == OP_INSERT) begin
            if (is_full) begin
              resp_d.status    = ST_FULL;
              resp_d.occupancy = OccW'(count_q);
              resp_d.is_empty  = 1'b0;
              state_d          = S_RESP;
            end else begin
              item_d.patron    = req_i.payload.patron_id;
              item_d.prio      = req_i.payload.priority_req;
              item_d.stamp     = stamp_q;
              stamp_d          = stamp_q + STAMP_BITS'(1);
              pos_d            = count_q[AW-1:0];
              count_d          = count_q + CW'(1);
              resp_d.status    = ST_INSERTED;
              resp_d.occupancy = OccW'(count_q + CW'(1));
              resp_d.is_empty  = 1'b0;
              state_d          = S_UP_RD;
            end
          end else begin
            if (count_q == '0) begin
              resp_d.status    = ST_EMPTY;
              resp_d.occupancy = '0;
              resp_d.is_empty  = 1'b1;
              state_d          = S_RESP;
            end else begin
              ram_raddr = '0;
              count_d   = count_q - CW'(1);
              state_d   = S_EX_ROOT;
            end
          end
        end
      end

      S_UP_RD: begin
        if (pos_q == '0) begin
          ram_we  = 1'b1;
          state_d = S_RESP;
        end else begin
          ram_raddr = parent;
          state_d   = S_UP_CMP;
        end
      end

      S_UP_CMP: begin
        ram_we = 1'b1;
        if (cmp_before) begin
          // Parent moves down into the hole; the hole rises.
          ram_wdata = ram_rdata;
          pos_d     = parent;
          state_d   = S_UP_RD;
        end else begin
          state_d = S_RESP;
        end
      end

      S_EX_ROOT: begin
        resp_d.status       = ST_EXTRACTED;
        resp_d.out_patron   = ram_rdata.patron;
        resp_d.out_priority = ram_rdata.prio;
        resp_d.occupancy    = OccW'(count_q);
        resp_d.is_empty     = (count_q == '0);
        ram_raddr           = count_q[AW-1:0];
        if (count_q == '0) begin
          stamp_d = '0;
          state_d = S_RESP;
        end else begin
          state_d = S_EX_LAST;
        end
      end

      S_EX_LAST: begin
        item_d  = ram_rdata;
        pos_d   = '0;
        state_d = S_DN_RD_L;
      end

      S_DN_RD_L: begin
        if (lchild >= count_w) begin
          ram_we  = 1'b1;
          state_d = S_RESP;
        end else begin
          ram_raddr = lchild[AW-1:0];
          state_d   = S_DN_RD_R;
        end
      end

      S_DN_RD_R: begin
        best_l_d = cmp_before;
        best_d   = cmp_before ? ram_rdata : item_q;
        has_r_d  = (rchild < count_w);
        ram_raddr = rchild[AW-1:0];
        state_d  = S_DN_CMP;
      end

      S_DN_CMP: begin
        ram_we = 1'b1;
        if (has_r_q && cmp_before) begin
          ram_wdata = ram_rdata;
          pos_d     = rchild[AW-1:0];
          state_d   = S_DN_RD_L;
        end else if (best_l_q) begin
          ram_wdata = best_q;
          pos_d     = lchild[AW-1:0];
          state_d   = S_DN_RD_L;
        end else begin
          state_d = S_RESP;
        end
      end

      S_RESP: begin
        if (!out_valid_q || rsp_o.ready) begin
          out_d       = resp_q;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      stamp_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      stamp_q     <= stamp_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q    <= pos_d;
    item_q   <= item_d;
    best_q   <= best_d;
    best_l_q <= best_l_d;
    has_r_q  <= has_r_d;
    resp_q   <= resp_d;
    out_q    <= out_d;
  end

  // The heap never holds more entries than it has room for.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(CAPACITY))
    else $error("heap entry count above capacity");

  // An idle heap with no entries always restarts its arrival stamps at zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE && count_q == '0) |-> (stamp_q == '0))
    else $error("arrival stamp not cleared on empty heap");

  // An accepted insert into a heap with room grows the count by one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && req_i.payload.opcode == OP_INSERT && !is_full)
      |=> (count_q == $past(count_q) + CW'(1)))
    else $error("insert did not grow the heap");

  // The RAM is written only while a request is being worked on.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE || state_q == S_RESP) |-> !ram_we)
    else $error("heap RAM written outside a request");

endmodule
